// ===== rtl/sts_pkg.sv =====
`default_nettype none

package sts_pkg;

  localparam int MAX_TOKEN_LEN = 99;
  localparam logic [6:0] LEN_LIMIT = 7'(MAX_TOKEN_LEN);
  localparam int NUM_KEYWORDS = 9;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_NUM  = 2'd2,
    MODE_OP   = 2'd3
  } sts_mode_t;

  localparam logic [2:0] CLS_KEYWORD = 3'd0;
  localparam logic [2:0] CLS_IDENT   = 3'd1;
  localparam logic [2:0] CLS_NUMBER  = 3'd2;
  localparam logic [2:0] CLS_OPER    = 3'd3;
  localparam logic [2:0] CLS_SYMBOL  = 3'd4;
  localparam logic [2:0] CLS_UNKNOWN = 3'd5;

  localparam logic [2:0] OP_EQ = 3'd0;
  localparam logic [2:0] OP_LT = 3'd1;
  localparam logic [2:0] OP_GT = 3'd2;
  localparam logic [2:0] OP_NOT = 3'd3;
  localparam logic [2:0] OP_LE = 3'd4;
  localparam logic [2:0] OP_GE = 3'd5;
  localparam logic [2:0] OP_NE = 3'd6;

  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Keyword text, left-justified, zero-padded to six characters
  localparam logic [47:0] KW_TEXT [NUM_KEYWORDS] = '{
    "SELECT",
    {"FROM", 16'h0000},
    {"WHERE", 8'h00},
    "INSERT",
    {"INTO", 16'h0000},
    "VALUES",
    "UPDATE",
    {"SET", 24'h000000},
    "DELETE"
  };

  localparam logic [6:0] KW_LEN [NUM_KEYWORDS] = '{
    7'd6, 7'd4, 7'd5, 7'd6, 7'd4, 7'd6, 7'd6, 7'd3, 7'd6
  };

  typedef struct packed {
    logic       is_alpha;
    logic       is_digit;
    logic       is_space;
    logic       is_newline;
    logic       is_eq;
    logic       is_cmp;
    logic       is_sym;
    logic       is_underscore;
    logic [7:0] upper;
    logic [3:0] digit;
  } sts_char_t;

  typedef struct packed {
    logic [2:0]  token_class;
    logic [15:0] line_number;
    logic [6:0]  token_length;
    logic [3:0]  keyword_index;
    logic [31:0] number_value;
    logic        number_overflow;
    logic [2:0]  operator_code;
    logic [7:0]  single_char;
    logic        run_end;
  } sts_token_t;

  function automatic logic [7:0] kw_char(input int idx, input logic [6:0] pos);
    logic [7:0] ch;
    case (pos)
      7'd0: ch = KW_TEXT[idx][47:40];
      7'd1: ch = KW_TEXT[idx][39:32];
      7'd2: ch = KW_TEXT[idx][31:24];
      7'd3: ch = KW_TEXT[idx][23:16];
      7'd4: ch = KW_TEXT[idx][15:8];
      7'd5: ch = KW_TEXT[idx][7:0];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Keywords whose character at position pos matches up
  function automatic logic [NUM_KEYWORDS-1:0] kw_match(input logic [6:0] pos,
                                                       input logic [7:0] up);
    logic [NUM_KEYWORDS-1:0] m;
    for (int i = 0; i < NUM_KEYWORDS; i++) begin
      m[i] = (kw_char(i, pos) == up);
    end
    return m;
  endfunction

  function automatic logic [2:0] op_single(input logic [7:0] c);
    logic [2:0] op;
    case (c)
      CH_LT:   op = OP_LT;
      CH_GT:   op = OP_GT;
      CH_BANG: op = OP_NOT;
      default: op = OP_EQ;
    endcase
    return op;
  endfunction

  function automatic sts_token_t mk_token(input logic [2:0] cls, input logic [15:0] line,
                                          input logic [6:0] len, input logic [2:0] op,
                                          input logic [7:0] sc);
    sts_token_t t;
    t = '0;
    t.token_class = cls;
    t.line_number = line;
    t.token_length = len;
    t.operator_code = op;
    t.single_char = sc;
    return t;
  endfunction

  function automatic sts_token_t flush_token(input sts_mode_t mode, input logic [15:0] line,
                                             input logic [6:0] len,
                                             input logic [NUM_KEYWORDS-1:0] cand,
                                             input logic [31:0] acc, input logic ovf,
                                             input logic [7:0] pend);
    sts_token_t t;
    t = '0;
    t.line_number = line;
    t.token_length = len;
    case (mode)
      MODE_WORD: begin
        t.token_class = CLS_IDENT;
        // scan downward so the lowest matching index wins
        for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
          if (cand[i] && KW_LEN[i] == len) begin
            t.token_class = CLS_KEYWORD;
            t.keyword_index = 4'(i);
          end
        end
      end
      MODE_NUM: begin
        t.token_class = CLS_NUMBER;
        t.number_value = acc;
        t.number_overflow = ovf;
      end
      MODE_OP: begin
        t.token_class = CLS_OPER;
        t.token_length = 7'd1;
        t.operator_code = op_single(pend);
      end
      default: begin
        t.token_class = CLS_UNKNOWN;
      end
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sts_char_class.sv =====
`default_nettype none

module sts_char_class
  import sts_pkg::*;
(
  input  wire logic [7:0] char_code,
  output sts_char_t       cls
);

  always_comb begin
    cls = '0;
    cls.is_alpha = (char_code inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    cls.is_digit = (char_code inside {[8'h30:8'h39]});
    cls.is_space = (char_code == 8'h20) || (char_code inside {[8'h09:8'h0D]});
    cls.is_newline = (char_code == CH_NEWLINE);
    cls.is_eq = (char_code == CH_EQ);
    cls.is_cmp = (char_code == CH_LT) || (char_code == CH_GT) || (char_code == CH_BANG);
    cls.is_sym = (char_code inside {8'h2C, 8'h3B, 8'h28, 8'h29});
    cls.is_underscore = (char_code == CH_UNDERSCORE);
    cls.upper = (char_code inside {[8'h61:8'h7A]}) ? char_code - 8'd32 : char_code;
    cls.digit = char_code[3:0];
  end

endmodule

`default_nettype wire

// ===== rtl/sts_scan.sv =====
`default_nettype none

module sts_scan
  import sts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] char_code,
  input  wire logic       final_char,
  input  wire sts_char_t  cc,
  output sts_token_t      tok0,
  output sts_token_t      tok1,
  output logic [1:0]      tok_count
);

  sts_mode_t                 mode, mode_next;
  logic [15:0]               line_count, line_next;
  logic [6:0]                cur_len, len_next;
  logic [NUM_KEYWORDS-1:0]   cand, cand_next;
  logic [31:0]               acc, acc_next;
  logic                      acc_ovf, acc_ovf_next;
  logic [7:0]                pend_op, pend_op_next;

  sts_token_t tok [2];
  logic [1:0] n;
  logic       done;
  logic [35:0] prod;

  always_comb begin
    mode_next = mode;
    line_next = line_count;
    len_next = cur_len;
    cand_next = cand;
    acc_next = acc;
    acc_ovf_next = acc_ovf;
    pend_op_next = pend_op;
    tok[0] = '0;
    tok[1] = '0;
    n = 2'd0;
    done = 1'b0;
    prod = ({4'h0, acc} << 3) + ({4'h0, acc} << 1) + {32'h0, cc.digit};

    // continue or close the token in progress
    case (mode)
      MODE_OP: begin
        if (cc.is_eq) begin
          tok[n[0]] = mk_token(CLS_OPER, line_count, 7'd2,
                               (pend_op == CH_LT) ? OP_LE :
                               (pend_op == CH_GT) ? OP_GE : OP_NE, 8'h00);
          n = n + 2'd1;
          done = 1'b1;
        end else begin
          tok[n[0]] = flush_token(mode, line_count, cur_len, cand, acc, acc_ovf, pend_op);
          n = n + 2'd1;
        end
        mode_next = MODE_IDLE;
      end
      MODE_WORD: begin
        if (cc.is_alpha || cc.is_digit || cc.is_underscore) begin
          cand_next = cand & kw_match(cur_len, cc.upper);
          if (cur_len < LEN_LIMIT) len_next = cur_len + 7'd1;
          done = 1'b1;
        end else begin
          tok[n[0]] = flush_token(mode, line_count, cur_len, cand, acc, acc_ovf, pend_op);
          n = n + 2'd1;
          mode_next = MODE_IDLE;
        end
      end
      MODE_NUM: begin
        if (cc.is_digit) begin
          if (prod[35:32] != 4'h0) begin
            acc_next = 32'hFFFF_FFFF;
            acc_ovf_next = 1'b1;
          end else begin
            acc_next = prod[31:0];
          end
          if (cur_len < LEN_LIMIT) len_next = cur_len + 7'd1;
          done = 1'b1;
        end else begin
          tok[n[0]] = flush_token(mode, line_count, cur_len, cand, acc, acc_ovf, pend_op);
          n = n + 2'd1;
          mode_next = MODE_IDLE;
        end
      end
      default: begin
      end
    endcase

    // start a new token on this character
    if (!done) begin
      if (cc.is_newline) begin
        if (line_count != 16'hFFFF) line_next = line_count + 16'd1;
      end else if (cc.is_space) begin
      end else if (cc.is_alpha) begin
        mode_next = MODE_WORD;
        len_next = 7'd1;
        cand_next = kw_match(7'd0, cc.upper);
      end else if (cc.is_digit) begin
        mode_next = MODE_NUM;
        len_next = 7'd1;
        acc_next = {28'h0, cc.digit};
        acc_ovf_next = 1'b0;
      end else if (cc.is_eq) begin
        tok[n[0]] = mk_token(CLS_OPER, line_count, 7'd1, OP_EQ, 8'h00);
        n = n + 2'd1;
      end else if (cc.is_cmp) begin
        mode_next = MODE_OP;
        pend_op_next = char_code;
      end else if (cc.is_sym) begin
        tok[n[0]] = mk_token(CLS_SYMBOL, line_count, 7'd1, OP_EQ, char_code);
        n = n + 2'd1;
      end else begin
        tok[n[0]] = mk_token(CLS_UNKNOWN, line_count, 7'd1, OP_EQ, char_code);
        n = n + 2'd1;
      end
    end

    // flush whatever is pending on the final character
    if (final_char && mode_next != MODE_IDLE) begin
      tok[n[0]] = flush_token(mode_next, line_next, len_next, cand_next, acc_next,
                              acc_ovf_next, pend_op_next);
      n = n + 2'd1;
      mode_next = MODE_IDLE;
    end

    if (n == 2'd1) tok[0].run_end = 1'b1;
    if (n == 2'd2) tok[1].run_end = 1'b1;
  end

  assign tok0 = tok[0];
  assign tok1 = tok[1];
  assign tok_count = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      line_count <= 16'd1;
      cur_len <= 7'd0;
      cand <= '1;
    end else if (accept) begin
      mode <= mode_next;
      line_count <= line_next;
      cur_len <= len_next;
      cand <= cand_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc <= acc_next;
      acc_ovf <= acc_ovf_next;
      pend_op <= pend_op_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sts_result_queue.sv =====
`default_nettype none

module sts_result_queue
  import sts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire sts_token_t tok0,
  input  wire sts_token_t tok1,
  input  wire logic [1:0] tok_count,
  output logic            out_valid,
  input  wire logic       out_stall,
  output sts_token_t      head
);

  sts_token_t slot0, slot1;
  logic [1:0] count;
  logic       pop;
  logic       push;

  assign pop = (count != 2'd0) && !out_stall;
  // take a new transaction only once the queue drains this cycle
  assign in_stall = !((count == 2'd0) || (count == 2'd1 && pop));
  assign push = in_valid && !in_stall;
  assign out_valid = (count != 2'd0);
  assign head = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push) begin
      count <= tok_count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot0 <= tok0;
      slot1 <= tok1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sql_token_scanner_core.sv =====
// Channel | Direction | Handshake          | Payload
// input   | in        | in_valid/in_stall  | char_code, final_char
// output  | out       | out_valid/out_stall| token_class .. single_char, run_end
//
// One character is taken per cycle while in_stall is low; its tokens appear registered on the next cycle.
// A character that yields two tokens holds the input off while the
// two-entry result queue drains; that queue's single read port sets the rate.
// Reset (rst, synchronous) returns to no pending token on line 1.
// in_stall rises whenever the result queue cannot be emptied in the current cycle.
`default_nettype none

module sql_token_scanner_core
  import sts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  char_code,
  input  wire logic        final_char,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       token_class,
  output logic [15:0]      line_number,
  output logic [6:0]       token_length,
  output logic [3:0]       keyword_index,
  output logic [31:0]      number_value,
  output logic             number_overflow,
  output logic [2:0]       operator_code,
  output logic [7:0]       single_char,
  output logic             run_end
);

  sts_char_t  cc;
  sts_token_t tok0, tok1, head;
  logic [1:0] tok_count;
  logic       accept;

  assign accept = in_valid && !in_stall;

  sts_char_class u_class (
    .char_code (char_code),
    .cls       (cc)
  );

  sts_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .char_code  (char_code),
    .final_char (final_char),
    .cc         (cc),
    .tok0       (tok0),
    .tok1       (tok1),
    .tok_count  (tok_count)
  );

  sts_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .tok0      (tok0),
    .tok1      (tok1),
    .tok_count (tok_count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign token_class = head.token_class;
  assign line_number = head.line_number;
  assign token_length = head.token_length;
  assign keyword_index = head.keyword_index;
  assign number_value = head.number_value;
  assign number_overflow = head.number_overflow;
  assign operator_code = head.operator_code;
  assign single_char = head.single_char;
  assign run_end = head.run_end;

endmodule

`default_nettype wire
